[design/aabb_pkg.sv]
package aabb_pkg;

    localparam int OPCODE_BITS = 2;

    localparam logic [OPCODE_BITS-1:0] OP_FRAME = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_QUERY = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 2'd2;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_COORD_BITS  = 16;
    localparam int DEF_ID_BITS     = 16;

endpackage

[design/aabb_ram.sv]
module aabb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/aabb_pair_overlap_finder_unit.sv]
// Brute-force 2D box overlap finder. Pulse start while busy is low to hand in one item.
// A frame box (store) is tested against every box stored in the current frame and
// then stored; a query box is tested without being stored; a clear starts a new frame.
// Each overlap leaves as one beat on o_strobe (for a frame box only with another body
// and when either box is dynamic); every item ends with one closing beat that has
// o_last set. Results cannot be held off, so take every strobed beat. A frame or
// query item streams the stored entries out of the box and tag memories one per
// cycle through their single read port, followed by a wait state in which the last
// read is evaluated and a closing state. A clear, an unused opcode, or any item on
// an empty table skips the scan and goes straight to the closing state. A frame box
// that finds the table full is tested but not stored and closes with o_table_full set.
module aabb_pair_overlap_finder_unit
    import aabb_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [OPCODE_BITS-1:0]       i_opcode,
    input  logic signed [COORD_BITS-1:0] i_min_x,
    input  logic signed [COORD_BITS-1:0] i_min_y,
    input  logic signed [COORD_BITS-1:0] i_max_x,
    input  logic signed [COORD_BITS-1:0] i_max_y,
    input  logic [ID_BITS-1:0]           i_body_id,
    input  logic                         i_is_dynamic,
    input  logic [ID_BITS-1:0]           i_node_id,
    output logic                         o_strobe,
    output logic [ID_BITS-1:0]           o_first_id,
    output logic [ID_BITS-1:0]           o_second_id,
    output logic                         o_hit_valid,
    output logic                         o_is_query_hit,
    output logic                         o_last,
    output logic                         o_table_full
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int BOX_W  = 4 * COORD_BITS;
    localparam int TAG_W  = 2 * ID_BITS + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_CLOSE = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_idx, n_idx;
    logic                         r_pend, n_pend;

    logic [OPCODE_BITS-1:0]       r_op;
    logic signed [COORD_BITS-1:0] r_lx, r_ly, r_hx, r_hy;
    logic [ID_BITS-1:0]           r_body;
    logic                         r_dyn;
    logic [ID_BITS-1:0]           r_node;

    logic [BOX_W-1:0]             box_q;
    logic [TAG_W-1:0]             tag_q;
    logic                         we;
    logic                         accept;
    logic                         full;
    logic                         scan_end;

    logic signed [COORD_BITS-1:0] s_lx, s_ly, s_hx, s_hy;
    logic [ID_BITS-1:0]           s_body;
    logic                         s_dyn;
    logic [ID_BITS-1:0]           s_node;
    logic                         overlap;
    logic                         hit;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign full     = (r_count == CW'(TABLE_DEPTH));
    assign scan_end = (CW'(r_idx) == r_count - CW'(1));
    assign we       = (r_state == ST_CLOSE) && (r_op == OP_FRAME) && !full;

    aabb_ram #(
        .WIDTH (BOX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_lx, r_ly, r_hx, r_hy}),
        .i_raddr (r_idx),
        .o_rdata (box_q)
    );

    aabb_ram #(
        .WIDTH (TAG_W),
        .DEPTH (TABLE_DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_body, r_dyn, r_node}),
        .i_raddr (r_idx),
        .o_rdata (tag_q)
    );

    assign s_lx   = $signed(box_q[4*COORD_BITS-1 -: COORD_BITS]);
    assign s_ly   = $signed(box_q[3*COORD_BITS-1 -: COORD_BITS]);
    assign s_hx   = $signed(box_q[2*COORD_BITS-1 -: COORD_BITS]);
    assign s_hy   = $signed(box_q[COORD_BITS-1:0]);
    assign s_body = tag_q[TAG_W-1 -: ID_BITS];
    assign s_dyn  = tag_q[ID_BITS];
    assign s_node = tag_q[ID_BITS-1:0];

    assign overlap = (s_lx <= r_hx) && (r_lx <= s_hx) && (s_ly <= r_hy) && (r_ly <= s_hy);

    always_comb begin
        hit = 1'b0;
        if (r_op == OP_QUERY) begin
            hit = overlap;
        end else begin
            hit = overlap && (s_body != r_body) && (s_dyn || r_dyn);
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_pend  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    if ((i_opcode == OP_FRAME || i_opcode == OP_QUERY) && r_count != '0) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_CLOSE;
                    end
                end
            end
            ST_SCAN: begin
                n_pend = 1'b1;
                if (scan_end) begin
                    n_state = ST_WAIT;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_WAIT: begin
                n_state = ST_CLOSE;
            end
            ST_CLOSE: begin
                n_state = ST_IDLE;
                if (r_op == OP_CLEAR) begin
                    n_count = '0;
                end else if (we) begin
                    n_count = r_count + CW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_opcode;
            r_lx   <= i_min_x;
            r_ly   <= i_min_y;
            r_hx   <= i_max_x;
            r_hy   <= i_max_y;
            r_body <= i_body_id;
            r_dyn  <= i_is_dynamic;
            r_node <= i_node_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe       <= 1'b0;
            o_hit_valid    <= 1'b0;
            o_is_query_hit <= 1'b0;
            o_last         <= 1'b0;
            o_table_full   <= 1'b0;
        end else if (r_pend && hit) begin
            o_strobe       <= 1'b1;
            o_first_id     <= s_node;
            o_second_id    <= r_node;
            o_hit_valid    <= 1'b1;
            o_is_query_hit <= (r_op == OP_QUERY);
            o_last         <= 1'b0;
            o_table_full   <= 1'b0;
        end else if (r_state == ST_CLOSE) begin
            o_strobe       <= 1'b1;
            o_first_id     <= '0;
            o_second_id    <= '0;
            o_hit_valid    <= 1'b0;
            o_is_query_hit <= (r_op == OP_QUERY);
            o_last         <= 1'b1;
            o_table_full   <= (r_op == OP_FRAME) && full;
        end else begin
            o_strobe       <= 1'b0;
            o_hit_valid    <= 1'b0;
            o_last         <= 1'b0;
            o_table_full   <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> r_state == ST_IDLE)
        else $error("closing beat while item still in progress");

    a_full_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_table_full |-> o_strobe && o_last && !o_is_query_hit)
        else $error("table full flag outside frame closing beat");

    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state) == ST_SCAN)
        else $error("read data evaluated without a scan read");

    a_hit_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid |-> o_strobe && !o_last)
        else $error("hit flag on a non-hit beat");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import aabb_pkg::*;

    localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
    localparam int COORD_BITS   = DEF_COORD_BITS;
    localparam int ID_BITS      = DEF_ID_BITS;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [COORD_BITS-1:0] C_MIN = 16'sh8000;
    localparam logic signed [COORD_BITS-1:0] C_MAX = 16'sh7FFF;

    typedef struct packed {
        logic [OPCODE_BITS-1:0]       op;
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic [ID_BITS-1:0]           body_id;
        logic                         is_dynamic;
        logic [ID_BITS-1:0]           node_id;
    } box_item_t;

    typedef struct packed {
        logic [ID_BITS-1:0] first_id;
        logic [ID_BITS-1:0] second_id;
        logic               hit_valid;
        logic               is_query_hit;
        logic               last;
        logic               table_full;
    } pair_beat_t;

    typedef struct packed {
        box_item_t  item;
        logic       typed;
        pair_beat_t beat;
    } stim_row_t;

    localparam pair_beat_t CLOSE_FRAME = '{16'h0, 16'h0, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam pair_beat_t CLOSE_QUERY = '{16'h0, 16'h0, 1'b0, 1'b1, 1'b1, 1'b0};
    localparam pair_beat_t NO_BEAT     = '0;

    localparam int N_DIRECTED = 16;
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{OP_QUERY, C_MIN, C_MIN, C_MAX, C_MAX, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b1, CLOSE_QUERY},
        '{'{OP_FRAME, C_MIN, C_MIN, C_MAX, C_MAX, 16'h0001, 1'b1, 16'hFFFF}, 1'b1, CLOSE_FRAME},
        '{'{OP_FRAME, 16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'h0002, 1'b0, 16'h0001},
          1'b0, NO_BEAT},
        '{'{OP_FRAME, 16'sd16, 16'sd16, 16'sd48, 16'sd48, 16'h0001, 1'b1, 16'h0002},
          1'b0, NO_BEAT},
        '{'{OP_FRAME, 16'sd100, 16'sd100, 16'sd200, 16'sd200, 16'h0003, 1'b0, 16'h0003},
          1'b0, NO_BEAT},
        '{'{OP_FRAME, 16'sd160, 16'sd0, 16'sd300, 16'sd50, 16'h0004, 1'b1, 16'h0004},
          1'b0, NO_BEAT},
        '{'{OP_FRAME, 16'sd200, 16'sd200, 16'sd220, 16'sd220, 16'h0005, 1'b1, 16'h0005},
          1'b0, NO_BEAT},
        '{'{OP_FRAME, 16'sd300, 16'sd300, -16'sd300, -16'sd300, 16'h0006, 1'b1, 16'h0006},
          1'b0, NO_BEAT},
        '{'{OP_QUERY, 16'sd0, 16'sd0, 16'sd50, 16'sd50, 16'h5555, 1'b0, 16'h0000},
          1'b0, NO_BEAT},
        '{'{OP_QUERY, C_MAX, C_MAX, C_MAX, C_MAX, 16'hAAAA, 1'b1, 16'hABCD},
          1'b0, NO_BEAT},
        '{'{OP_UNUSED, C_MIN, C_MAX, C_MIN, C_MAX, 16'h1234, 1'b1, 16'h4321},
          1'b1, CLOSE_FRAME},
        '{'{OP_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 1'b0, 16'h0000},
          1'b1, CLOSE_FRAME},
        '{'{OP_QUERY, C_MIN, C_MIN, C_MAX, C_MAX, 16'h0000, 1'b0, 16'h7777},
          1'b1, CLOSE_QUERY},
        '{'{OP_FRAME, C_MIN, C_MIN, C_MIN, C_MIN, 16'hFFFF, 1'b0, 16'h0000},
          1'b1, CLOSE_FRAME},
        '{'{OP_FRAME, C_MIN, C_MIN, 16'sd0, 16'sd0, 16'h0000, 1'b1, 16'hFFFF},
          1'b0, NO_BEAT},
        '{'{OP_CLEAR, C_MAX, C_MAX, C_MAX, C_MAX, 16'hFFFF, 1'b1, 16'hFFFF},
          1'b1, CLOSE_FRAME}
    };

    localparam int SENDER_IDLE [4] = '{0, 46, 0, 38};

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [OPCODE_BITS-1:0]       i_opcode = '0;
    logic signed [COORD_BITS-1:0] i_min_x = '0;
    logic signed [COORD_BITS-1:0] i_min_y = '0;
    logic signed [COORD_BITS-1:0] i_max_x = '0;
    logic signed [COORD_BITS-1:0] i_max_y = '0;
    logic [ID_BITS-1:0]           i_body_id = '0;
    logic                         i_is_dynamic = 1'b0;
    logic [ID_BITS-1:0]           i_node_id = '0;
    logic                         o_strobe;
    logic [ID_BITS-1:0]           o_first_id;
    logic [ID_BITS-1:0]           o_second_id;
    logic                         o_hit_valid;
    logic                         o_is_query_hit;
    logic                         o_last;
    logic                         o_table_full;

    box_item_t  frame_boxes [TABLE_DEPTH];
    int         frame_fill = 0;
    pair_beat_t pending_pairs [$];
    int         fail_count = 0;
    int         cycle_count = 0;

    aabb_pair_overlap_finder_unit #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_min_x       (i_min_x),
        .i_min_y       (i_min_y),
        .i_max_x       (i_max_x),
        .i_max_y       (i_max_y),
        .i_body_id     (i_body_id),
        .i_is_dynamic  (i_is_dynamic),
        .i_node_id     (i_node_id),
        .o_strobe      (o_strobe),
        .o_first_id    (o_first_id),
        .o_second_id   (o_second_id),
        .o_hit_valid   (o_hit_valid),
        .o_is_query_hit(o_is_query_hit),
        .o_last        (o_last),
        .o_table_full  (o_table_full)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit boxes_overlap(box_item_t a, box_item_t b);
        return $signed(a.min_x) <= $signed(b.max_x) && $signed(b.min_x) <= $signed(a.max_x) &&
               $signed(a.min_y) <= $signed(b.max_y) && $signed(b.min_y) <= $signed(a.max_y);
    endfunction

    task automatic broad_phase_step(input box_item_t it, input bit record);
        pair_beat_t beat;
        beat = CLOSE_FRAME;
        if (it.op == OP_FRAME || it.op == OP_QUERY) begin
            for (int k = 0; k < frame_fill; k++) begin
                if (boxes_overlap(frame_boxes[k], it) &&
                    (it.op == OP_QUERY ||
                     (frame_boxes[k].body_id != it.body_id &&
                      (frame_boxes[k].is_dynamic || it.is_dynamic)))) begin
                    if (record)
                        pending_pairs.push_back('{first_id: frame_boxes[k].node_id,
                                                  second_id: it.node_id,
                                                  hit_valid: 1'b1,
                                                  is_query_hit: it.op == OP_QUERY,
                                                  last: 1'b0,
                                                  table_full: 1'b0});
                end
            end
        end
        if (it.op == OP_FRAME) begin
            if (frame_fill < TABLE_DEPTH) begin
                frame_boxes[frame_fill] = it;
                frame_fill++;
            end else begin
                beat.table_full = 1'b1;
            end
        end else if (it.op == OP_QUERY) begin
            beat = CLOSE_QUERY;
        end else if (it.op == OP_CLEAR) begin
            frame_fill = 0;
        end
        if (record)
            pending_pairs.push_back(beat);
    endtask

    // hold the item until accepted, dropping start at random while waiting
    task automatic apply_item(input box_item_t it, input int idle_pct,
                              input bit typed, input pair_beat_t typed_beat);
        start        <= ($urandom_range(99) >= idle_pct);
        i_opcode     <= it.op;
        i_min_x      <= it.min_x;
        i_min_y      <= it.min_y;
        i_max_x      <= it.max_x;
        i_max_y      <= it.max_y;
        i_body_id    <= it.body_id;
        i_is_dynamic <= it.is_dynamic;
        i_node_id    <= it.node_id;
        forever begin
            @(posedge i_clk);
            if (start && busy === 1'b0)
                break;
            start <= ($urandom_range(99) >= idle_pct);
        end
        broad_phase_step(it, !typed);
        if (typed)
            pending_pairs.push_back(typed_beat);
    endtask

    always @(posedge i_clk) begin : pair_check
        pair_beat_t seen;
        pair_beat_t want;
        int         hit_at;
        if (i_rst_n && o_strobe !== 1'b0) begin
            seen = '{o_first_id, o_second_id, o_hit_valid, o_is_query_hit, o_last,
                     o_table_full};
            if (pending_pairs.size() == 0) begin
                $error("result beat with nothing pending: first_id %0h second_id %0h last %0b",
                       seen.first_id, seen.second_id, seen.last);
                fail_count++;
            end else begin
                hit_at = -1;
                if (seen.last !== 1'b1) begin
                    for (int j = 0; j < pending_pairs.size() && !pending_pairs[j].last; j++)
                        if (hit_at < 0 && pending_pairs[j] === seen)
                            hit_at = j;
                end
                if (hit_at < 0)
                    hit_at = 0;
                want = pending_pairs[hit_at];
                pending_pairs.delete(hit_at);
                if (want.first_id !== seen.first_id) begin
                    $error("first_id: expected %0h, got %0h", want.first_id, seen.first_id);
                    fail_count++;
                end
                if (want.second_id !== seen.second_id) begin
                    $error("second_id: expected %0h, got %0h", want.second_id, seen.second_id);
                    fail_count++;
                end
                if (want.hit_valid !== seen.hit_valid) begin
                    $error("hit_valid: expected %0b, got %0b", want.hit_valid, seen.hit_valid);
                    fail_count++;
                end
                if (want.is_query_hit !== seen.is_query_hit) begin
                    $error("is_query_hit: expected %0b, got %0b",
                           want.is_query_hit, seen.is_query_hit);
                    fail_count++;
                end
                if (want.last !== seen.last) begin
                    $error("last: expected %0b, got %0b", want.last, seen.last);
                    fail_count++;
                end
                if (want.table_full !== seen.table_full) begin
                    $error("table_full: expected %0b, got %0b", want.table_full, seen.table_full);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        box_item_t          it;
        logic [15:0]        base_x;
        logic [15:0]        base_y;
        logic [ID_BITS-1:0] body_pool [3];
        int                 counted;
        int                 group;
        int                 group_len;
        int                 idle;
        int                 pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++)
            apply_item(DIRECTED_ROWS[r].item, 0, DIRECTED_ROWS[r].typed,
                       DIRECTED_ROWS[r].beat);

        counted = 0;
        group = 0;
        while (counted < RANDOM_ITEMS) begin
            idle = SENDER_IDLE[(counted * 4 / RANDOM_ITEMS) % 4];
            base_x = 16'($urandom);
            base_y = 16'($urandom);
            foreach (body_pool[p])
                body_pool[p] = ID_BITS'($urandom);
            group_len = (group == 0 || $urandom_range(5) == 0) ? $urandom_range(33, 38)
                                                                : $urandom_range(1, 12);
            it = box_item_t'($urandom);
            it.op = OP_CLEAR;
            apply_item(it, idle, 1'b0, NO_BEAT);
            counted++;
            for (int n = 0; n < group_len; n++) begin
                pick = $urandom_range(99);
                it.op = (pick < 5) ? OP_UNUSED :
                        (pick < 25 && group_len <= TABLE_DEPTH) ? OP_QUERY : OP_FRAME;
                if ($urandom_range(9) == 0) begin
                    it.min_x = COORD_BITS'($urandom);
                    it.min_y = COORD_BITS'($urandom);
                    it.max_x = COORD_BITS'($urandom);
                    it.max_y = COORD_BITS'($urandom);
                end else begin
                    it.min_x = COORD_BITS'(base_x + $urandom_range(0, 1023));
                    it.min_y = COORD_BITS'(base_y + $urandom_range(0, 1023));
                    it.max_x = COORD_BITS'(it.min_x + $urandom_range(0, 320));
                    it.max_y = COORD_BITS'(it.min_y + $urandom_range(0, 320));
                end
                it.body_id = ($urandom_range(99) < 85) ? body_pool[$urandom_range(2)]
                                                       : ID_BITS'($urandom);
                it.is_dynamic = 1'($urandom_range(1));
                it.node_id = ID_BITS'($urandom);
                apply_item(it, idle, 1'b0, NO_BEAT);
                if (it.op != OP_UNUSED)
                    counted++;
            end
            group++;
        end
        start <= 1'b0;

        while (pending_pairs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_pairs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
